FILE: rtl/u8sd_pkg.sv
// Package for the UTF-8 stream decoder: result and sequence-state types,
// byte-class constants and the lead-byte helper functions.
// No dependencies.
package u8sd_pkg;

    localparam int unsigned CP_W  = 31;
    localparam int unsigned LEN_W = 3;

    // Sequence lengths that a lead byte may open
    localparam logic [3:0] SEQ_MIN = 4'd2;
    localparam logic [3:0] SEQ_MAX = 4'd6;

    localparam logic [LEN_W-1:0] LEN_ONE = 3'd1;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        logic             bad_lead;
    } u8sd_result_t;

    typedef struct packed {
        logic [CP_W-1:0]  accumulator;
        logic [LEN_W-1:0] bytes_left;
        logic [LEN_W-1:0] seq_total;
    } u8sd_state_t;

    // Count leading one bits of a byte, 0 to 8
    function automatic logic [3:0] lead_ones(input logic [7:0] b);
        logic [3:0] n;
        logic       run;
        n   = 4'd0;
        run = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            run = run & b[i];
            n   = n + {3'd0, run};
        end
        return n;
    endfunction

    // Payload bits kept from a lead byte of a sequence of length n
    function automatic logic [7:0] lead_mask(input logic [3:0] n);
        return 8'hFF >> (n + 4'd1);
    endfunction

endpackage

FILE: rtl/u8sd_step.sv
// One decode step: takes the held byte and the sequence state, returns the
// next state and the result item, if any. Pure combinational.
// Depends on u8sd_pkg.
module u8sd_step
    import u8sd_pkg::*;
(
    input  logic [7:0]   in_byte,
    input  u8sd_state_t  state,
    output u8sd_state_t  state_next,
    output logic         emit,
    output u8sd_result_t result
);

    logic [3:0] ones;
    logic [7:0] kept;

    assign ones = lead_ones(in_byte);
    assign kept = in_byte & lead_mask(ones);

    always_comb begin
        state_next = state;
        emit       = 1'b0;
        result     = '0;
        priority if (state.bytes_left != '0) begin
            // Continuation: shift in low six bits, byte is not checked
            state_next.accumulator = {state.accumulator[CP_W-7:0], in_byte[5:0]};
            state_next.bytes_left  = state.bytes_left - LEN_W'(1);
            emit                   = (state.bytes_left == LEN_W'(1));
            result.code_point      = state_next.accumulator;
            result.seq_length      = state.seq_total;
        end else if (!in_byte[7]) begin
            emit              = 1'b1;
            result.code_point = {{(CP_W-8){1'b0}}, in_byte};
            result.seq_length = LEN_ONE;
        end else if (ones < SEQ_MIN || ones > SEQ_MAX) begin
            // Lone continuation, 0xFE or 0xFF: flag, open nothing
            emit              = 1'b1;
            result.seq_length = LEN_ONE;
            result.bad_lead   = 1'b1;
        end else begin
            state_next.accumulator = {{(CP_W-8){1'b0}}, kept};
            state_next.bytes_left  = LEN_W'(ones - 4'd1);
            state_next.seq_total   = LEN_W'(ones);
        end
    end

endmodule

FILE: rtl/u8sd_out_stage.sv
// Result register of the decoder: holds one finished item until the
// downstream side takes it. Depends on u8sd_pkg.
module u8sd_out_stage
    import u8sd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  u8sd_result_t     result,
    output logic             can_take,
    output logic             m_valid,
    input  logic             m_ready,
    output u8sd_result_t     m_result
);

    logic         valid_reg;
    u8sd_result_t result_reg;

    assign can_take = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

FILE: rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: input byte register, sequence
// state, decode step and result register. Depends on u8sd_pkg, u8sd_step,
// u8sd_out_stage.
//
//   channel | ports                                      | direction
//   input   | s_valid s_ready s_in_byte[7:0]             | in
//   result  | m_valid m_ready m_code_point[30:0]         | out
//           | m_seq_length[2:0] m_bad_lead               |
//
// One byte per cycle sustained while the result register is not stalled; a
// result shows on m_valid once the byte that completes it has passed the
// input register and then the result register. Bytes that open a sequence,
// or continue it without completing it, give no result item.
// Reset clears the sequence state to idle and drops both registers.
// A stalled result holds the input register; the held byte advances as
// soon as the result register is free or being taken in the same cycle.
module utf8_stream_decoder
    import u8sd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_in_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CP_W-1:0]     m_code_point,
    output logic [LEN_W-1:0]    m_seq_length,
    output logic                m_bad_lead
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    u8sd_state_t  state_reg;
    u8sd_state_t  state_next;
    logic         emit;
    u8sd_result_t result;
    u8sd_result_t m_result;
    logic         can_take;
    logic         advance;

    assign advance = in_valid_reg && can_take;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    u8sd_step u_step (
        .in_byte    (in_byte_reg),
        .state      (state_reg),
        .state_next (state_next),
        .emit       (emit),
        .result     (result)
    );

    u8sd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && emit),
        .result   (result),
        .can_take (can_take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_code_point = m_result.code_point;
    assign m_seq_length = m_result.seq_length;
    assign m_bad_lead   = m_result.bad_lead;

endmodule

FILE: rtl/u8sd_checker.sv
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// Depends on u8sd_pkg and utf8_stream_decoder.
module u8sd_checker
    import u8sd_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input logic [CP_W-1:0]  m_code_point,
    input logic [LEN_W-1:0] m_seq_length,
    input logic             m_bad_lead
);

    // Hold a stalled result item
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_point)
            && $stable(m_seq_length) && $stable(m_bad_lead))
        else $error("stalled result item changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_bad_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_lead |-> m_code_point == '0 && m_seq_length == LEN_ONE)
        else $error("bad lead item not zero code point of length one");

    a_ascii: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_bad_lead && m_seq_length == LEN_ONE |-> m_code_point < 31'd128)
        else $error("one-byte item above 0x7F");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_seq_length != 3'd0 && m_seq_length != 3'd7)
        else $error("sequence length out of range");

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (.*);
